[sv/srlp_pkg.sv]
`default_nettype none

package srlp_pkg;

    // item kind codes
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // record status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_INVALID = 2'd1;
    localparam logic [1:0] STATUS_EOF     = 2'd2;

    // character codes
    localparam logic [7:0] CHAR_S     = 8'h53;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_F     = 8'h46;
    localparam logic [7:0] CHAR_1     = 8'h31;
    localparam logic [7:0] CHAR_2     = 8'h32;
    localparam logic [7:0] CHAR_3     = 8'h33;
    localparam logic [7:0] CHAR_7     = 8'h37;
    localparam logic [7:0] CHAR_8     = 8'h38;
    localparam logic [3:0] HEX_A_BASE = 4'd10;

    localparam int OUT_TDATA_W = 72;

    typedef struct packed {
        logic       sol;
        logic [7:0] chr;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data;
        logic [31:0] addr;
        logic [7:0]  index;
        logic [1:0]  status;
        logic [7:0]  rtype;
        logic [7:0]  count;
    } result_t;

endpackage

`default_nettype wire

[sv/srlp_input_stage.sv]
`default_nettype none

module srlp_input_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire srlp_pkg::in_item_t s_item,
    input  wire logic               advance,
    output logic                    item_valid,
    output srlp_pkg::in_item_t      item
);

    logic               valid_reg;
    logic               valid_next;
    srlp_pkg::in_item_t item_reg;

    assign s_tready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        if (s_tvalid && s_tready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= s_item;
        end
    end

endmodule

`default_nettype wire

[sv/srlp_parse_core.sv]
`default_nettype none

module srlp_parse_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire srlp_pkg::in_item_t item,
    output logic                    res_valid,
    output srlp_pkg::result_t       res
);

    logic [9:0]  pos_reg,    pos_next;
    logic        active_reg, active_next;
    logic [3:0]  hi_reg,     hi_next;
    logic [7:0]  type_reg,   type_next;
    logic [2:0]  abytes_reg, abytes_next;
    logic [7:0]  count_reg,  count_next;
    logic [31:0] addr_reg,   addr_next;
    logic [7:0]  done_reg,   done_next;
    logic [7:0]  sum_reg,    sum_next;

    logic [3:0]  lo_nib;
    logic [7:0]  byte_val;
    logic [9:0]  pos_less3;
    logic [8:0]  ordinal;
    logic [8:0]  min_count;

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [3:0] n;
        n = 4'd0;
        if (c >= srlp_pkg::CHAR_0 && c <= srlp_pkg::CHAR_9)
        begin
            n = 4'(c - srlp_pkg::CHAR_0);
        end
        else if (c >= srlp_pkg::CHAR_A && c <= srlp_pkg::CHAR_F)
        begin
            n = 4'(c - srlp_pkg::CHAR_A) + srlp_pkg::HEX_A_BASE;
        end
        return n;
    endfunction

    assign lo_nib    = nibble_of(item.chr);
    assign byte_val  = {hi_reg, lo_nib};
    assign pos_less3 = pos_reg - 10'd3;
    assign ordinal   = pos_less3[9:1];
    assign min_count = {6'd0, abytes_reg} + 9'd1;

    always_comb
    begin
        pos_next    = pos_reg;
        active_next = active_reg;
        hi_next     = hi_reg;
        type_next   = type_reg;
        abytes_next = abytes_reg;
        count_next  = count_reg;
        addr_next   = addr_reg;
        done_next   = done_reg;
        sum_next    = sum_reg;

        res_valid  = 1'b0;
        res.kind   = srlp_pkg::KIND_STATUS;
        res.data   = 8'd0;
        res.addr   = addr_reg;
        res.index  = done_reg;
        res.status = srlp_pkg::STATUS_OK;
        res.rtype  = type_reg;
        res.count  = count_reg;

        if (item.sol)
        begin
            // a new line drops whatever record was open
            pos_next    = 10'd1;
            active_next = 1'b1;
            hi_next     = 4'd0;
            type_next   = 8'd0;
            abytes_next = 3'd0;
            count_next  = 8'd0;
            addr_next   = 32'd0;
            done_next   = 8'd0;
            sum_next    = 8'd0;
            res.addr    = 32'd0;
            res.index   = 8'd0;
            res.rtype   = 8'd0;
            res.count   = 8'd0;
            if (item.chr != srlp_pkg::CHAR_S)
            begin
                active_next = 1'b0;
                res_valid   = 1'b1;
                res.status  = srlp_pkg::STATUS_INVALID;
            end
        end
        else if (active_reg)
        begin
            pos_next = pos_reg + 10'd1;
            if (pos_reg == 10'd1)
            begin
                type_next = item.chr;
                if (item.chr == srlp_pkg::CHAR_1)
                begin
                    abytes_next = 3'd2;
                end
                else if (item.chr == srlp_pkg::CHAR_2)
                begin
                    abytes_next = 3'd3;
                end
                else if (item.chr == srlp_pkg::CHAR_3)
                begin
                    abytes_next = 3'd4;
                end
                else
                begin
                    abytes_next = 3'd0;
                end
            end
            else if (!pos_reg[0])
            begin
                hi_next = lo_nib;
            end
            else if (pos_reg == 10'd3)
            begin
                count_next = byte_val;
                sum_next   = byte_val;
                res.count  = byte_val;
                if (type_reg == srlp_pkg::CHAR_7 || type_reg == srlp_pkg::CHAR_8 ||
                    type_reg == srlp_pkg::CHAR_9)
                begin
                    active_next = 1'b0;
                    res_valid   = 1'b1;
                    res.status  = srlp_pkg::STATUS_EOF;
                end
                else if (abytes_reg == 3'd0 || {1'b0, byte_val} < min_count)
                begin
                    active_next = 1'b0;
                    res_valid   = 1'b1;
                    res.status  = srlp_pkg::STATUS_INVALID;
                end
            end
            else if (ordinal <= {6'd0, abytes_reg})
            begin
                addr_next = {addr_reg[23:0], byte_val};
                sum_next  = sum_reg + byte_val;
            end
            else if (ordinal < {1'b0, count_reg})
            begin
                res_valid = 1'b1;
                res.kind  = srlp_pkg::KIND_DATA;
                res.data  = byte_val;
                done_next = done_reg + 8'd1;
                sum_next  = sum_reg + byte_val;
            end
            else
            begin
                // checksum character closes the record
                active_next = 1'b0;
                res_valid   = 1'b1;
                res.status  = (~sum_reg == byte_val) ? srlp_pkg::STATUS_OK
                                                     : srlp_pkg::STATUS_INVALID;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= 10'd0;
            active_reg <= 1'b0;
            hi_reg     <= 4'd0;
            type_reg   <= 8'd0;
            abytes_reg <= 3'd0;
            count_reg  <= 8'd0;
            addr_reg   <= 32'd0;
            done_reg   <= 8'd0;
            sum_reg    <= 8'd0;
        end
        else if (step)
        begin
            pos_reg    <= pos_next;
            active_reg <= active_next;
            hi_reg     <= hi_next;
            type_reg   <= type_next;
            abytes_reg <= abytes_next;
            count_reg  <= count_next;
            addr_reg   <= addr_next;
            done_reg   <= done_next;
            sum_reg    <= sum_next;
        end
    end

endmodule

`default_nettype wire

[sv/srlp_output_stage.sv]
`default_nettype none

module srlp_output_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire srlp_pkg::result_t res,
    output logic                   advance,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output srlp_pkg::result_t      m_res
);

    logic              valid_reg;
    logic              valid_next;
    srlp_pkg::result_t res_reg;

    assign advance  = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_res    = res_reg;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

endmodule

`default_nettype wire

[sv/srlp_line_parser_top.sv]
`default_nettype none

// a character is held in the input register, its result is then registered in the result
// register, from which it transfers out on the master side
// throughput: one character per cycle, sustained while the master side keeps tready high
// the rate is set by the single pass of nibble decode and state update between the
// input register and the result register
// reset: rst_n is asynchronous, active low; it clears both valid flags and all parser state

module srec_line_parser_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // character side
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        s_tuser,   // [0] start_of_line
    // result side
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // [7:0] data_byte, [39:8] record_address,
                                        // [47:40] byte_index, [49:48] status,
                                        // [57:50] record_type, [65:58] byte_count,
                                        // [71:66] zero
    output logic             m_tuser    // [0] item_kind
);

    srlp_pkg::in_item_t s_item;
    srlp_pkg::in_item_t item;
    srlp_pkg::result_t  res;
    srlp_pkg::result_t  m_res;
    logic               item_valid;
    logic               advance;
    logic               step;
    logic               res_valid;

    assign s_item.sol = s_tuser;
    assign s_item.chr = s_tdata;

    // the held character is consumed whenever the result register can take a transfer
    assign step = item_valid && advance;

    srlp_input_stage u_input (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // decode and record state, at most one result per character
    srlp_parse_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    srlp_output_stage u_output (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (step && res_valid),
        .res      (res),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (m_res)
    );

    // pack the result fields, lowest field first
    assign m_tdata = {6'd0, m_res.count, m_res.rtype, m_res.status,
                      m_res.index, m_res.addr, m_res.data};
    assign m_tuser = m_res.kind;

endmodule

`default_nettype wire
